@@ rtl/circular_buffer_deque_macros.svh @@
// assertion macros for the circular buffer deque
// used by the top level; expects clk and rst in the including scope
`ifndef CIRCULAR_BUFFER_DEQUE_MACROS_SVH
`define CIRCULAR_BUFFER_DEQUE_MACROS_SVH

// condition holds at every edge outside reset
`define CBD_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define CBD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cbd_pkg.sv @@
// shared constants, codes and types for the circular buffer deque
// no dependencies
package cbd_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OCC_W    = 5;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;
  localparam int S_TDATA_W = ((DATA_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((DATA_W + OCC_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

  // ring index one step forward, wrapping at the capacity
  function automatic logic [IDX_W-1:0] idx_fwd(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(CAPACITY - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  // ring index one step back, wrapping at slot zero
  function automatic logic [IDX_W-1:0] idx_back(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_W'(CAPACITY - 1) : idx - IDX_W'(1);
  endfunction

endpackage

@@ rtl/cbd_ram.sv @@
// ring storage: one write port, one read port with registered read data
// depends on cbd_pkg
module cbd_ram (
  input  logic                       clk,
  input  cbd_pkg::ram_wr_t           wr,
  input  cbd_pkg::ram_rd_t           rd,
  output logic [cbd_pkg::DATA_W-1:0] rd_data
);

  logic [cbd_pkg::DATA_W-1:0] mem [cbd_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

@@ rtl/circular_buffer_deque.sv @@
// circular buffer deque top level: pointer control, output register
// depends on cbd_pkg, cbd_ram and circular_buffer_deque_macros.svh
//
//  channel  | dir | tdata                              | tuser
//  ---------+-----+------------------------------------+----------------
//  s_       | in  | [31:0] data_value                  | [1:0] action
//  m_       | out | [31:0] popped_value, [36:32] occ.  | [1:0] status
//
// a push, a rejected push and a pop on an empty queue load the output register directly
// a pop that hits an entry first does a ram read, then loads the output register
// the ring store sits in a single-port-read ram with registered read data
// rst is synchronous; it clears pointers, count and valid flags, not the ram
// a waiting result in the output register does not stall input as long as
// m_tready takes it in the same cycle
`include "circular_buffer_deque_macros.svh"

module circular_buffer_deque (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cbd_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] data_value
  input  logic [cbd_pkg::ACT_W-1:0]     s_tuser,   // [1:0] action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cbd_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] popped_value, [36:32] occupancy
  output logic [cbd_pkg::STAT_W-1:0]    m_tuser    // [1:0] status
);

  // pointer and occupancy state
  logic [cbd_pkg::IDX_W-1:0] head, head_next;
  logic [cbd_pkg::IDX_W-1:0] tail, tail_next;
  logic [cbd_pkg::CNT_W-1:0] count, count_next;

  // pop waiting for ram read data
  logic pend;

  // output register
  logic signed [cbd_pkg::DATA_W-1:0] out_value;
  cbd_pkg::status_t                  out_status;
  logic [cbd_pkg::OCC_W-1:0]         out_occ;

  logic                       s_acc;
  cbd_pkg::action_t           act;
  logic                       empty, full;
  logic                       load_now;
  cbd_pkg::status_t           res_status;
  cbd_pkg::ram_wr_t           ram_wr;
  cbd_pkg::ram_rd_t           ram_rd;
  logic [cbd_pkg::DATA_W-1:0] rd_data;

  // hold off input while a pop waits on the ram or the output is blocked
  assign s_tready = !pend && (!m_tvalid || m_tready);
  assign s_acc    = s_tvalid && s_tready;
  assign act      = cbd_pkg::action_t'(s_tuser);
  assign empty    = (count == '0);
  assign full     = (count == cbd_pkg::CNT_W'(cbd_pkg::CAPACITY));

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    res_status  = cbd_pkg::ST_DONE;
    load_now    = s_acc;
    ram_wr.en   = 1'b0;
    ram_wr.addr = head;
    ram_wr.data = s_tdata[cbd_pkg::DATA_W-1:0];
    ram_rd.en   = 1'b0;
    ram_rd.addr = head;
    if (s_acc) begin
      case (act) inside
        cbd_pkg::ACT_PUSH_FRONT, cbd_pkg::ACT_PUSH_BACK: begin
          if (full) begin
            res_status = cbd_pkg::ST_FULL;
          end else begin
            ram_wr.en  = 1'b1;
            count_next = count + cbd_pkg::CNT_W'(1);
            if (empty) begin
              // first entry always lands in slot zero
              head_next   = '0;
              tail_next   = '0;
              ram_wr.addr = '0;
            end else if (act == cbd_pkg::ACT_PUSH_FRONT) begin
              head_next   = cbd_pkg::idx_back(head);
              ram_wr.addr = head_next;
            end else begin
              tail_next   = cbd_pkg::idx_fwd(tail);
              ram_wr.addr = tail_next;
            end
          end
        end
        cbd_pkg::ACT_POP_FRONT, cbd_pkg::ACT_POP_BACK: begin
          if (empty) begin
            res_status = cbd_pkg::ST_EMPTY;
          end else begin
            // result comes from the ram in the next cycle
            ram_rd.en  = 1'b1;
            load_now   = 1'b0;
            count_next = count - cbd_pkg::CNT_W'(1);
            if (act == cbd_pkg::ACT_POP_FRONT) begin
              ram_rd.addr = head;
              head_next   = cbd_pkg::idx_fwd(head);
            end else begin
              ram_rd.addr = tail;
              tail_next   = cbd_pkg::idx_back(tail);
            end
            // last entry gone: both pointers back to slot zero
            if (count == cbd_pkg::CNT_W'(1)) begin
              head_next = '0;
              tail_next = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  cbd_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      pend  <= ram_rd.en;
      if (load_now) begin
        // pushes and failed pops report all ones
        m_tvalid   <= 1'b1;
        out_value  <= '1;
        out_status <= res_status;
        out_occ    <= cbd_pkg::OCC_W'(count_next);
      end else if (pend) begin
        // count already holds the post-pop occupancy
        m_tvalid   <= 1'b1;
        out_value  <= rd_data;
        out_status <= cbd_pkg::ST_DONE;
        out_occ    <= cbd_pkg::OCC_W'(count);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = cbd_pkg::M_TDATA_W'({out_occ, out_value});
  assign m_tuser = out_status;

  // occupancy never passes the ring size
  `CBD_ASSERT_ALWAYS(a_count_bound, count <= cbd_pkg::CNT_W'(cbd_pkg::CAPACITY), "count over capacity")
  // empty queue parks both pointers at slot zero
  `CBD_ASSERT_ALWAYS(a_empty_ptrs, !empty || (head == '0 && tail == '0), "empty queue with pointers off zero")
  // a single entry is both front and back
  `CBD_ASSERT_ALWAYS(a_single_ptrs, count != cbd_pkg::CNT_W'(1) || head == tail, "single entry with head and tail apart")
  // a pending pop always presents its result on the next edge
  `CBD_ASSERT_NEXT(a_pend_loads, pend, m_tvalid && out_status == cbd_pkg::ST_DONE, "pending pop not delivered")

endmodule
